[rtl/core/sfpa_pkg.sv]
// ----------------------------------------------------------------------------
// sfpa_pkg
// Shared types, codes and reset values for the sensor frame parser.
// ----------------------------------------------------------------------------
package sfpa_pkg;

    localparam int ByteW  = 8;
    localparam int ValW   = 12;
    localparam int SmokeW = 20;
    localparam int AccW   = 22;
    localparam int KindW  = 2;
    localparam int LeftW  = 3;
    localparam int PhaseW = 2;

    localparam int ApbDataW = 32;
    localparam int ApbAddrW = 5;
    localparam int RegIdxW  = 3;

    // Frame kinds
    localparam logic [KindW-1:0] KIND_TH     = 2'd0;
    localparam logic [KindW-1:0] KIND_MOTION = 2'd1;
    localparam logic [KindW-1:0] KIND_SMOKE  = 2'd2;

    // Parser phases
    localparam logic [PhaseW-1:0] PH_IDLE   = 2'd0;
    localparam logic [PhaseW-1:0] PH_TH     = 2'd1;
    localparam logic [PhaseW-1:0] PH_MOTION = 2'd2;
    localparam logic [PhaseW-1:0] PH_SMOKE  = 2'd3;

    // Payload byte counts per frame
    localparam logic [LeftW-1:0] LEN_TH     = 3'd4;
    localparam logic [LeftW-1:0] LEN_MOTION = 3'd1;
    localparam logic [LeftW-1:0] LEN_SMOKE  = 3'd5;
    localparam logic [LeftW-1:0] LEFT_HUMID = 3'd2;

    // Register indexes
    localparam logic [RegIdxW-1:0] REG_TAG_TH    = 3'd0;
    localparam logic [RegIdxW-1:0] REG_TAG_MOT   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_TAG_SMOKE = 3'd2;
    localparam logic [RegIdxW-1:0] REG_TEMP_UP   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_TEMP_LO   = 3'd4;
    localparam logic [RegIdxW-1:0] REG_HUM_UP    = 3'd5;
    localparam logic [RegIdxW-1:0] REG_HUM_LO    = 3'd6;
    localparam logic [RegIdxW-1:0] REG_SMOKE_UP  = 3'd7;

    // Register reset values
    localparam logic [ByteW-1:0]  RST_TAG_TH    = 8'd1;
    localparam logic [ByteW-1:0]  RST_TAG_MOT   = 8'd2;
    localparam logic [ByteW-1:0]  RST_TAG_SMOKE = 8'd3;
    localparam logic [ValW-1:0]   RST_TEMP_UP   = 12'd50;
    localparam logic [ValW-1:0]   RST_TEMP_LO   = 12'd0;
    localparam logic [ValW-1:0]   RST_HUM_UP    = 12'd90;
    localparam logic [ValW-1:0]   RST_HUM_LO    = 12'd20;
    localparam logic [SmokeW-1:0] RST_SMOKE_UP  = 20'd10000;

    // floor(x / 5) = (x * ceil(2^22 / 5)) >> 22 for every x below 2^22
    localparam int                DivShift = 22;
    localparam logic [SmokeW-1:0] DIV5_MUL = 20'd838861;
    localparam int                ProdW    = AccW + SmokeW;

    typedef struct packed {
        logic [ByteW-1:0]  tag_th;
        logic [ByteW-1:0]  tag_motion;
        logic [ByteW-1:0]  tag_smoke;
        logic [ValW-1:0]   temp_upper;
        logic [ValW-1:0]   temp_lower;
        logic [ValW-1:0]   humidity_upper;
        logic [ValW-1:0]   humidity_lower;
        logic [SmokeW-1:0] smoke_upper;
    } cfg_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ValW-1:0]  temperature;
        logic [ValW-1:0]  humidity;
        logic [ByteW-1:0] motion;
        logic [AccW-1:0]  acc;
    } frame_t;

endpackage

[rtl/core/sfpa_if.sv]
// ----------------------------------------------------------------------------
// sfpa interfaces
// Valid/ready channels for received bytes and decoded frames.
// ----------------------------------------------------------------------------
interface sfpa_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfpa_pkg::ByteW-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpa_out_if;
    logic                        valid;
    logic                        ready;
    logic [sfpa_pkg::KindW-1:0]  frame_kind;
    logic [sfpa_pkg::ValW-1:0]   temperature;
    logic [sfpa_pkg::ValW-1:0]   humidity;
    logic [sfpa_pkg::ByteW-1:0]  motion;
    logic [sfpa_pkg::SmokeW-1:0] smoke;
    logic                        alarm;

    modport source (output valid, output frame_kind, output temperature, output humidity,
                    output motion, output smoke, output alarm, input ready);
    modport sink   (input valid, input frame_kind, input temperature, input humidity,
                    input motion, input smoke, input alarm, output ready);
endinterface

[rtl/core/sensor_frame_parser_alarm.sv]
// ----------------------------------------------------------------------------
// sensor_frame_parser_alarm
// Parses tagged sensor frames from a byte stream and flags threshold alarms.
// ----------------------------------------------------------------------------
// in_ch carries one received byte per item; out_ch carries one item per
// completed frame (temperature/humidity, motion or smoke) with its alarm bit.
// Bytes that complete no frame, and unknown tags in idle, give no item.
// The APB port holds the three tags and five thresholds; write it only while
// no frame is in flight. pready is always high.
// Throughput: one byte per cycle while in_ch.ready is high. A frame's
// closing byte passes through the frame register and then the output
// register, whose stage holds the divide-by-five multiply.
// Reset returns the parser to idle, empties both registers and loads the
// default tags and thresholds. When out_ch stalls, the frame register keeps
// taking bytes until a second finished frame is waiting; in_ch.ready then
// drops until out_ch.ready returns.
// ----------------------------------------------------------------------------
module sensor_frame_parser_alarm
(
    input  logic                           clk,
    input  logic                           rst_n,
    sfpa_in_if.sink                        in_ch,
    sfpa_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfpa_pkg::ApbAddrW-1:0]  paddr,
    input  logic [sfpa_pkg::ApbDataW-1:0]  pwdata,
    output logic [sfpa_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready
);

    sfpa_pkg::cfg_t   cfg;
    sfpa_pkg::frame_t frm;
    logic             frm_valid;
    logic             frm_take;
    logic             in_ready;

    assign in_ch.ready = in_ready;

    sfpa_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfpa_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .rx_byte   (in_ch.rx_byte),
        .in_ready  (in_ready),
        .cfg       (cfg),
        .frm_take  (frm_take),
        .frm_valid (frm_valid),
        .frm       (frm)
    );

    sfpa_result u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .frm_valid (frm_valid),
        .frm       (frm),
        .frm_take  (frm_take),
        .out_ch    (out_ch)
    );

endmodule

[rtl/core/sfpa_regs.sv]
// ----------------------------------------------------------------------------
// sfpa_regs
// APB configuration registers: frame tags and alarm thresholds.
// ----------------------------------------------------------------------------
module sfpa_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfpa_pkg::ApbAddrW-1:0]  paddr,
    input  logic [sfpa_pkg::ApbDataW-1:0]  pwdata,
    output logic [sfpa_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    output sfpa_pkg::cfg_t                 cfg
);

    sfpa_pkg::cfg_t                   cfg_reg;
    sfpa_pkg::cfg_t                   cfg_next;
    logic [sfpa_pkg::RegIdxW-1:0]     idx;
    logic                             wr;

    assign idx    = paddr[sfpa_pkg::ApbAddrW-1:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                sfpa_pkg::REG_TAG_TH:    cfg_next.tag_th         = pwdata[7:0];
                sfpa_pkg::REG_TAG_MOT:   cfg_next.tag_motion     = pwdata[7:0];
                sfpa_pkg::REG_TAG_SMOKE: cfg_next.tag_smoke      = pwdata[7:0];
                sfpa_pkg::REG_TEMP_UP:   cfg_next.temp_upper     = pwdata[11:0];
                sfpa_pkg::REG_TEMP_LO:   cfg_next.temp_lower     = pwdata[11:0];
                sfpa_pkg::REG_HUM_UP:    cfg_next.humidity_upper = pwdata[11:0];
                sfpa_pkg::REG_HUM_LO:    cfg_next.humidity_lower = pwdata[11:0];
                sfpa_pkg::REG_SMOKE_UP:  cfg_next.smoke_upper    = pwdata[19:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sfpa_pkg::REG_TAG_TH:    prdata = 32'(cfg_reg.tag_th);
            sfpa_pkg::REG_TAG_MOT:   prdata = 32'(cfg_reg.tag_motion);
            sfpa_pkg::REG_TAG_SMOKE: prdata = 32'(cfg_reg.tag_smoke);
            sfpa_pkg::REG_TEMP_UP:   prdata = 32'(cfg_reg.temp_upper);
            sfpa_pkg::REG_TEMP_LO:   prdata = 32'(cfg_reg.temp_lower);
            sfpa_pkg::REG_HUM_UP:    prdata = 32'(cfg_reg.humidity_upper);
            sfpa_pkg::REG_HUM_LO:    prdata = 32'(cfg_reg.humidity_lower);
            sfpa_pkg::REG_SMOKE_UP:  prdata = 32'(cfg_reg.smoke_upper);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tag_th         <= sfpa_pkg::RST_TAG_TH;
            cfg_reg.tag_motion     <= sfpa_pkg::RST_TAG_MOT;
            cfg_reg.tag_smoke      <= sfpa_pkg::RST_TAG_SMOKE;
            cfg_reg.temp_upper     <= sfpa_pkg::RST_TEMP_UP;
            cfg_reg.temp_lower     <= sfpa_pkg::RST_TEMP_LO;
            cfg_reg.humidity_upper <= sfpa_pkg::RST_HUM_UP;
            cfg_reg.humidity_lower <= sfpa_pkg::RST_HUM_LO;
            cfg_reg.smoke_upper    <= sfpa_pkg::RST_SMOKE_UP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/sfpa_parser.sv]
// ----------------------------------------------------------------------------
// sfpa_parser
// Frame state machine and decimal accumulation; registers each completed frame.
// ----------------------------------------------------------------------------
module sfpa_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sfpa_pkg::ByteW-1:0]   rx_byte,
    output logic                         in_ready,
    input  sfpa_pkg::cfg_t               cfg,
    input  logic                         frm_take,
    output logic                         frm_valid,
    output sfpa_pkg::frame_t             frm
);

    logic [sfpa_pkg::PhaseW-1:0] phase_reg, phase_next;
    logic [sfpa_pkg::LeftW-1:0]  left_reg, left_next, left_dec;
    logic [sfpa_pkg::AccW-1:0]   acc_reg, acc_next, acc_step;
    logic [sfpa_pkg::ValW-1:0]   held_reg, held_next;
    logic                        frm_valid_reg;
    sfpa_pkg::frame_t            frm_reg, frm_next;
    logic                        accept;
    logic                        emit;

    assign in_ready  = !frm_valid_reg || frm_take;
    assign accept    = in_valid && in_ready;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    assign acc_step = sfpa_pkg::AccW'(acc_reg * 4'd10) + sfpa_pkg::AccW'(rx_byte);
    assign left_dec = left_reg - 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        emit       = 1'b0;
        frm_next   = '0;
        if (accept)
        begin
            unique case (phase_reg)
                sfpa_pkg::PH_IDLE:
                begin
                    acc_next = '0;
                    priority if (rx_byte == cfg.tag_th)
                    begin
                        phase_next = sfpa_pkg::PH_TH;
                        left_next  = sfpa_pkg::LEN_TH;
                    end
                    else if (rx_byte == cfg.tag_motion)
                    begin
                        phase_next = sfpa_pkg::PH_MOTION;
                        left_next  = sfpa_pkg::LEN_MOTION;
                    end
                    else if (rx_byte == cfg.tag_smoke)
                    begin
                        phase_next = sfpa_pkg::PH_SMOKE;
                        left_next  = sfpa_pkg::LEN_SMOKE;
                    end
                    else
                    begin
                        phase_next = sfpa_pkg::PH_IDLE;
                    end
                end
                sfpa_pkg::PH_MOTION:
                begin
                    emit            = 1'b1;
                    frm_next.kind   = sfpa_pkg::KIND_MOTION;
                    frm_next.motion = rx_byte;
                    phase_next      = sfpa_pkg::PH_IDLE;
                    left_next       = '0;
                    acc_next        = '0;
                end
                sfpa_pkg::PH_TH:
                begin
                    left_next = left_dec;
                    acc_next  = acc_step;
                    if (left_dec == sfpa_pkg::LEFT_HUMID)
                    begin
                        held_next = acc_step[sfpa_pkg::ValW-1:0];
                        acc_next  = '0;
                    end
                    else if (left_dec == '0)
                    begin
                        emit                 = 1'b1;
                        frm_next.kind        = sfpa_pkg::KIND_TH;
                        frm_next.temperature = held_reg;
                        frm_next.humidity    = acc_step[sfpa_pkg::ValW-1:0];
                        phase_next           = sfpa_pkg::PH_IDLE;
                        acc_next             = '0;
                    end
                end
                sfpa_pkg::PH_SMOKE:
                begin
                    left_next = left_dec;
                    acc_next  = acc_step;
                    if (left_dec == '0)
                    begin
                        emit          = 1'b1;
                        frm_next.kind = sfpa_pkg::KIND_SMOKE;
                        frm_next.acc  = acc_step;
                        phase_next    = sfpa_pkg::PH_IDLE;
                        acc_next      = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sfpa_pkg::PH_IDLE;
            left_reg      <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            if (in_ready)
            begin
                frm_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frm_reg <= frm_next;
        end
    end

endmodule

[rtl/core/sfpa_result.sv]
// ----------------------------------------------------------------------------
// sfpa_result
// Smoke scaling, threshold checks and the output register.
// ----------------------------------------------------------------------------
module sfpa_result
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfpa_pkg::cfg_t       cfg,
    input  logic                 frm_valid,
    input  sfpa_pkg::frame_t     frm,
    output logic                 frm_take,
    sfpa_out_if.source           out_ch
);

    logic [sfpa_pkg::ProdW-1:0]  prod;
    logic [sfpa_pkg::SmokeW-1:0] smoke;
    logic                        alarm_th;
    logic                        alarm;
    logic                        out_valid_reg;
    logic [sfpa_pkg::KindW-1:0]  kind_reg;
    logic [sfpa_pkg::ValW-1:0]   temp_reg;
    logic [sfpa_pkg::ValW-1:0]   hum_reg;
    logic [sfpa_pkg::ByteW-1:0]  motion_reg;
    logic [sfpa_pkg::SmokeW-1:0] smoke_reg;
    logic                        alarm_reg;

    assign prod  = sfpa_pkg::ProdW'(frm.acc) * sfpa_pkg::ProdW'(sfpa_pkg::DIV5_MUL);
    assign smoke = prod[sfpa_pkg::DivShift +: sfpa_pkg::SmokeW];

    assign alarm_th = (frm.temperature < cfg.temp_lower) || (frm.temperature > cfg.temp_upper)
                   || (frm.humidity < cfg.humidity_lower) || (frm.humidity > cfg.humidity_upper);

    always_comb
    begin
        unique case (frm.kind)
            sfpa_pkg::KIND_TH:    alarm = alarm_th;
            sfpa_pkg::KIND_SMOKE: alarm = smoke > cfg.smoke_upper;
            default:              alarm = 1'b0;
        endcase
    end

    assign frm_take = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (frm_take)
        begin
            out_valid_reg <= frm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_take && frm_valid)
        begin
            kind_reg   <= frm.kind;
            temp_reg   <= frm.temperature;
            hum_reg    <= frm.humidity;
            motion_reg <= frm.motion;
            smoke_reg  <= smoke;
            alarm_reg  <= alarm;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.frame_kind  = kind_reg;
    assign out_ch.temperature = temp_reg;
    assign out_ch.humidity    = hum_reg;
    assign out_ch.motion      = motion_reg;
    assign out_ch.smoke       = smoke_reg;
    assign out_ch.alarm       = alarm_reg;

endmodule

[rtl/core/sfpa_checker.sv]
// ----------------------------------------------------------------------------
// sfpa_checker
// Port-level checks for the sensor frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfpa_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [sfpa_pkg::KindW-1:0]    frame_kind,
    input  logic [sfpa_pkg::ValW-1:0]     temperature,
    input  logic [sfpa_pkg::SmokeW-1:0]   smoke,
    input  logic                          alarm
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_kind) && $stable(smoke))
        else $error("result changed while stalled");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked although output drains");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_kind != 2'd3)
        else $error("undefined frame kind");

    a_motion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == sfpa_pkg::KIND_MOTION |->
            !alarm && temperature == '0 && smoke == '0)
        else $error("motion result carries other fields");

endmodule

bind sensor_frame_parser_alarm sfpa_checker u_sfpa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .frame_kind  (out_ch.frame_kind),
    .temperature (out_ch.temperature),
    .smoke       (out_ch.smoke),
    .alarm       (out_ch.alarm)
);

[bench/sfpa_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_frame_checker
// Watches the byte and frame channels and the register port of the sensor
// frame parser. It decodes every accepted byte with its own copy of the tags,
// thresholds and frame state, queues each finished frame, and compares every
// frame leaving the block, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module sfpa_frame_checker
    import sfpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sfpa_in_if                  in_ch,
    sfpa_out_if                 out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  frames_due
);

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [ValW-1:0]   temperature;
        logic [ValW-1:0]   humidity;
        logic [ByteW-1:0]  motion;
        logic [SmokeW-1:0] smoke;
        logic              alarm;
    } sensor_frame_t;

    cfg_t              regs;
    logic [PhaseW-1:0] phase;
    logic [LeftW-1:0]  left;
    logic [AccW-1:0]   acc;
    logic [ValW-1:0]   held_temp;
    sensor_frame_t     queued_frames[$];
    sensor_frame_t     want;
    sensor_frame_t     got;

    function automatic void drop_frame();
        phase = PH_IDLE;
        left  = '0;
        acc   = '0;
    endfunction

    function automatic bit decode_byte(input logic [ByteW-1:0] b, output sensor_frame_t res);
        logic [SmokeW-1:0] scaled;
        res = '0;
        if (phase == PH_IDLE)
        begin
            if (b == regs.tag_th)
            begin
                phase = PH_TH;
                left  = LEN_TH;
            end
            else if (b == regs.tag_motion)
            begin
                phase = PH_MOTION;
                left  = LEN_MOTION;
            end
            else if (b == regs.tag_smoke)
            begin
                phase = PH_SMOKE;
                left  = LEN_SMOKE;
            end
            acc = '0;
            return 1'b0;
        end
        if (phase == PH_MOTION)
        begin
            res.kind   = KIND_MOTION;
            res.motion = b;
            drop_frame();
            return 1'b1;
        end
        acc  = AccW'(acc * 10 + b);
        left = left - 1'b1;
        if (phase == PH_TH)
        begin
            if (left == LEFT_HUMID)
            begin
                held_temp = acc[ValW-1:0];
                acc       = '0;
                return 1'b0;
            end
            if (left == '0)
            begin
                res.kind        = KIND_TH;
                res.temperature = held_temp;
                res.humidity    = acc[ValW-1:0];
                res.alarm       = (held_temp < regs.temp_lower) ||
                                  (held_temp > regs.temp_upper) ||
                                  (acc[ValW-1:0] < regs.humidity_lower) ||
                                  (acc[ValW-1:0] > regs.humidity_upper);
                drop_frame();
                return 1'b1;
            end
            return 1'b0;
        end
        if (left == '0)
        begin
            scaled     = SmokeW'(acc / 5);
            res.kind   = KIND_SMOKE;
            res.smoke  = scaled;
            res.alarm  = scaled > regs.smoke_upper;
            drop_frame();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.tag_th         = RST_TAG_TH;
            regs.tag_motion     = RST_TAG_MOT;
            regs.tag_smoke      = RST_TAG_SMOKE;
            regs.temp_upper     = RST_TEMP_UP;
            regs.temp_lower     = RST_TEMP_LO;
            regs.humidity_upper = RST_HUM_UP;
            regs.humidity_lower = RST_HUM_LO;
            regs.smoke_upper    = RST_SMOKE_UP;
            drop_frame();
            held_temp  = '0;
            queued_frames.delete();
            mismatches = 0;
            frames_due <= 0;
        end
        else
        begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = '{out_ch.frame_kind, out_ch.temperature, out_ch.humidity,
                        out_ch.motion, out_ch.smoke, out_ch.alarm};
                if (queued_frames.size() == 0)
                begin
                    $error("frame_kind: expected no item, actual %0d", got.kind);
                    mismatches++;
                end
                else
                begin
                    want = queued_frames.pop_front();
                    check_field("frame_kind", 32'(want.kind), 32'(got.kind));
                    check_field("temperature", 32'(want.temperature), 32'(got.temperature));
                    check_field("humidity", 32'(want.humidity), 32'(got.humidity));
                    check_field("motion", 32'(want.motion), 32'(got.motion));
                    check_field("smoke", 32'(want.smoke), 32'(got.smoke));
                    check_field("alarm", 32'(want.alarm), 32'(got.alarm));
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                if (decode_byte(in_ch.rx_byte, want))
                    queued_frames.push_back(want);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ApbAddrW-1:2])
                    REG_TAG_TH:    regs.tag_th         = pwdata[ByteW-1:0];
                    REG_TAG_MOT:   regs.tag_motion     = pwdata[ByteW-1:0];
                    REG_TAG_SMOKE: regs.tag_smoke      = pwdata[ByteW-1:0];
                    REG_TEMP_UP:   regs.temp_upper     = pwdata[ValW-1:0];
                    REG_TEMP_LO:   regs.temp_lower     = pwdata[ValW-1:0];
                    REG_HUM_UP:    regs.humidity_upper = pwdata[ValW-1:0];
                    REG_HUM_LO:    regs.humidity_lower = pwdata[ValW-1:0];
                    default:       regs.smoke_upper    = pwdata[SmokeW-1:0];
                endcase
            end
            frames_due <= queued_frames.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the sensor frame parser bench. Drives a byte stream of directed and
// random frames with noise between them, stalls both channels at random,
// reprograms tags and thresholds between phases and gives the verdict from
// the frame checker's mismatch and pending-frame counts.
// ----------------------------------------------------------------------------
module tb;
    import sfpa_pkg::*;

    localparam int TotalBytes = 1850;
    localparam int PhaseBytes = 150;
    localparam int StallLimit = 1000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int   mismatches;
    int   frames_due;
    int   quiet_cycles = 0;
    int   sent = 0;
    int   phase_no = 0;
    int   phase_end;
    bit   tx_gaps = 1'b1;
    bit   rx_gaps = 1'b1;
    cfg_t live_cfg;
    cfg_t next_cfg;

    logic [ByteW-1:0] opening[$];

    sfpa_in_if  in_ch();
    sfpa_out_if out_ch();

    sensor_frame_parser_alarm u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfpa_frame_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .frames_due (frames_due)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_gaps)
            begin
                int unsigned gap;
                gap = $urandom_range(0, 8);
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
        end
    end

    task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(input cfg_t c);
        apb_write(REG_TAG_TH, ApbDataW'(c.tag_th));
        apb_write(REG_TAG_MOT, ApbDataW'(c.tag_motion));
        apb_write(REG_TAG_SMOKE, ApbDataW'(c.tag_smoke));
        apb_write(REG_TEMP_UP, ApbDataW'(c.temp_upper));
        apb_write(REG_TEMP_LO, ApbDataW'(c.temp_lower));
        apb_write(REG_HUM_UP, ApbDataW'(c.humidity_upper));
        apb_write(REG_HUM_LO, ApbDataW'(c.humidity_lower));
        apb_write(REG_SMOKE_UP, ApbDataW'(c.smoke_upper));
        live_cfg = c;
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    // hold the stream until every frame has left and the pipeline is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (frames_due == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [ByteW-1:0] pick_digit();
        if ($urandom_range(0, 4) == 0)
            return ByteW'($urandom_range(0, 255));
        return ByteW'($urandom_range(0, 9));
    endfunction

    function automatic logic [SmokeW-1:0] pick_limit(input int unsigned typical,
                                                     input logic [SmokeW-1:0] top);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return top;
            default: return SmokeW'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic cfg_t pick_config(input int n);
        cfg_t c;
        if (n == 0)
        begin
            c = '0;
            c.tag_motion = '1;
            c.tag_smoke  = 8'h80;
        end
        else if (n == 1)
        begin
            c = '1;
            c.tag_th         = 8'h5a;
            c.tag_motion     = 8'ha5;
            c.tag_smoke      = 8'h0f;
            c.temp_lower     = '0;
            c.humidity_lower = '0;
        end
        else
        begin
            c.tag_th         = ByteW'($urandom_range(0, 255));
            c.tag_motion     = ByteW'($urandom_range(0, 255));
            c.tag_smoke      = ByteW'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0)
                c.tag_smoke = c.tag_motion;
            if ($urandom_range(0, 5) == 0)
                c.tag_motion = c.tag_th;
            c.temp_upper     = ValW'(pick_limit(110, '1));
            c.temp_lower     = ValW'(pick_limit(60, '1));
            c.humidity_upper = ValW'(pick_limit(110, '1));
            c.humidity_lower = ValW'(pick_limit(60, '1));
            c.smoke_upper    = pick_limit(22000, '1);
        end
        return c;
    endfunction

    task automatic send_frame(input logic [KindW-1:0] kind);
        int unsigned n;
        case (kind)
            KIND_TH:
            begin
                send_byte(live_cfg.tag_th);
                n = LEN_TH;
            end
            KIND_MOTION:
            begin
                send_byte(live_cfg.tag_motion);
                n = LEN_MOTION;
            end
            default:
            begin
                send_byte(live_cfg.tag_smoke);
                n = LEN_SMOKE;
            end
        endcase
        repeat (n)
            send_byte(kind == KIND_MOTION ? ByteW'($urandom_range(0, 255)) : pick_digit());
        sent += n + 1;
    endtask

    // idle bytes that open no frame
    task automatic send_noise();
        logic [ByteW-1:0] b;
        repeat ($urandom_range(1, 3))
        begin
            do b = ByteW'($urandom_range(0, 255));
            while (b == live_cfg.tag_th || b == live_cfg.tag_motion ||
                   b == live_cfg.tag_smoke);
            send_byte(b);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= '0;
        live_cfg = '{RST_TAG_TH, RST_TAG_MOT, RST_TAG_SMOKE, RST_TEMP_UP, RST_TEMP_LO,
                     RST_HUM_UP, RST_HUM_LO, RST_SMOKE_UP};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        opening = '{8'h00,
                    RST_TAG_TH, 8'd2, 8'd5, 8'd4, 8'd5,
                    RST_TAG_TH, 8'hff, 8'hff, 8'hff, 8'hff,
                    RST_TAG_MOT, 8'hff,
                    RST_TAG_MOT, RST_TAG_TH,
                    RST_TAG_SMOKE, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
                    RST_TAG_SMOKE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        foreach (opening[i])
            send_byte(opening[i]);
        sent += opening.size();
        settle();

        // equal tags: temperature/humidity first, then motion over smoke
        next_cfg = '1;
        next_cfg.tag_th         = 8'h07;
        next_cfg.tag_motion     = 8'h07;
        next_cfg.tag_smoke      = 8'h07;
        next_cfg.temp_lower     = '0;
        next_cfg.humidity_lower = '0;
        load_config(next_cfg);
        send_byte(8'h07);
        send_byte(8'd3);
        send_byte(8'd0);
        send_byte(8'd6);
        send_byte(8'd0);
        settle();
        apb_write(REG_TAG_TH, ApbDataW'(8'h20));
        live_cfg.tag_th = 8'h20;
        send_byte(8'h07);
        send_byte(8'h55);
        sent += 7;
        settle();

        while (sent < TotalBytes)
        begin
            load_config(pick_config(phase_no));
            tx_gaps   = (phase_no % 4) < 2;
            rx_gaps   = (phase_no % 4) == 0 || (phase_no % 4) == 2;
            phase_end = sent + PhaseBytes;
            while (sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_noise();
                send_frame(KindW'($urandom_range(0, 2)));
            end
            settle();
            phase_no++;
        end

        if (mismatches == 0 && frames_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
